>>> design/fdw_pkg.sv
// Shared types and constants for the deduplicating FIFO window.
package fdw_pkg;

  localparam int ID_W             = 10;
  localparam int ID_SPACE         = 1 << ID_W;
  localparam int CAP_W            = 6;
  localparam int WINDOW_DEPTH_DEF = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  typedef struct packed {
    logic [ID_W-1:0] caller_id;
    logic            is_final;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0] held_id;
    logic            last_of_run;
  } result_t;

  typedef struct packed {
    logic            rd_en;
    logic [ID_W-1:0] rd_addr;
    logic            wr_en;
    logic [ID_W-1:0] wr_addr;
    logic            wr_bit;
  } pres_req_t;

endpackage

>>> design/fifo_dedup_window_core.sv
// Top level of the deduplicating FIFO window: control sequencer and memories.
//
//   channel   signals                        direction  transfer
//   item      start, busy, item              in         start && !busy
//   result    result_valid, result           out        result_valid, one cycle
//   config    cfg_valid, cfg_ready, cfg_data in         cfg_valid && cfg_ready
//
// A word whose identifier is present is dropped and a new one is inserted; an insertion
// with eviction also passes through ST_EVICT to clear the evicted presence bit, set by
// the registered read and the single write port of the presence memory.
// A final word then dumps the n held entries, one ring read a cycle.
// After reset the presence memory is swept clear for every identifier with busy high.
// The result side cannot stall; configuration is always ready.
module fifo_dedup_window_core #(
  parameter int WINDOW_DEPTH = fdw_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  fdw_pkg::item_t            item,
  output logic                      result_valid,
  output fdw_pkg::result_t          result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [fdw_pkg::CAP_W-1:0] cfg_data
);

  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOOK  = 2'd1;
  localparam logic [1:0] ST_EVICT = 2'd2;
  localparam logic [1:0] ST_DUMP  = 2'd3;

  logic [1:0]                state, state_next;
  logic [fdw_pkg::CAP_W-1:0] capacity;
  logic [PTR_W-1:0]          oldest, oldest_next;
  logic [CNT_W-1:0]          count, count_next;
  logic [CNT_W-1:0]          rd_k, rd_k_next;
  logic                      out_v, out_v_next;
  logic                      out_last, out_last_next;
  logic [fdw_pkg::ID_W-1:0]  id_q;
  logic                      final_q;

  logic                      accept, clearing, pres_bit, full, issue;
  logic [6:0]                cap_eff;
  fdw_pkg::pres_req_t        preq;
  logic                      ring_wr_en, ring_rd_en;
  logic [CNT_W-1:0]          ring_rd_off;
  logic [fdw_pkg::ID_W-1:0]  ring_rd_data;

  assign cfg_ready = 1'b1;
  assign busy      = clearing || (state != ST_IDLE);
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= fdw_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_comb begin
    if (capacity == '0) begin
      cap_eff = 7'd1;
    end else if (7'(capacity) > 7'(WINDOW_DEPTH)) begin
      cap_eff = 7'(WINDOW_DEPTH);
    end else begin
      cap_eff = 7'(capacity);
    end
    full  = (7'(count) >= cap_eff) && (count != '0);
    issue = (state == ST_DUMP) && (rd_k != count);
  end

  always_comb begin
    state_next    = state;
    oldest_next   = oldest;
    count_next    = count;
    rd_k_next     = rd_k;
    out_v_next    = 1'b0;
    out_last_next = 1'b0;
    ring_wr_en    = 1'b0;
    ring_rd_en    = 1'b0;
    ring_rd_off   = '0;
    preq.rd_en    = accept;
    preq.rd_addr  = item.caller_id;
    preq.wr_en    = 1'b0;
    preq.wr_addr  = id_q;
    preq.wr_bit   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          ring_rd_en = 1'b1;
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        rd_k_next = '0;
        if (pres_bit) begin
          state_next = final_q ? ST_DUMP : ST_IDLE;
        end else begin
          ring_wr_en  = 1'b1;
          preq.wr_en  = 1'b1;
          preq.wr_bit = 1'b1;
          if (full) begin
            oldest_next = (oldest == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : oldest + 1'b1;
            state_next  = ST_EVICT;
          end else begin
            count_next = count + 1'b1;
            state_next = final_q ? ST_DUMP : ST_IDLE;
          end
        end
      end
      ST_EVICT: begin
        preq.wr_en   = 1'b1;
        preq.wr_addr = ring_rd_data;
        state_next   = final_q ? ST_DUMP : ST_IDLE;
      end
      ST_DUMP: begin
        ring_rd_off = rd_k;
        if (issue) begin
          ring_rd_en    = 1'b1;
          rd_k_next     = rd_k + 1'b1;
          out_v_next    = 1'b1;
          out_last_next = (rd_k + 1'b1) == count;
        end
        if (out_v) begin
          preq.wr_en   = 1'b1;
          preq.wr_addr = ring_rd_data;
        end
        if (out_v && out_last) begin
          oldest_next = '0;
          count_next  = '0;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      oldest   <= '0;
      count    <= '0;
      rd_k     <= '0;
      out_v    <= 1'b0;
      out_last <= 1'b0;
    end else begin
      state    <= state_next;
      oldest   <= oldest_next;
      count    <= count_next;
      rd_k     <= rd_k_next;
      out_v    <= out_v_next;
      out_last <= out_last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      id_q    <= item.caller_id;
      final_q <= item.is_final;
    end
  end

  fdw_pres_map u_pres (
    .clk      (clk),
    .rst      (rst),
    .req      (preq),
    .rd_bit   (pres_bit),
    .clearing (clearing)
  );

  fdw_ring #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .PTR_W        (PTR_W),
    .CNT_W        (CNT_W)
  ) u_ring (
    .clk     (clk),
    .base    (oldest),
    .wr_en   (ring_wr_en),
    .wr_off  (count),
    .wr_data (id_q),
    .rd_en   (ring_rd_en),
    .rd_off  (ring_rd_off),
    .rd_data (ring_rd_data)
  );

  assign result_valid       = out_v;
  assign result.held_id     = ring_rd_data;
  assign result.last_of_run = out_last;

  a_result_only_in_dump: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> state == ST_DUMP)
    else $error("Result strobe outside the dump.");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= WINDOW_DEPTH)
    else $error("Entry count exceeds the window depth.");

  a_dump_empties: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_of_run |=> count == '0 && oldest == '0)
    else $error("Window not emptied after the dump.");

  a_accept_looks_up: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> state == ST_LOOK)
    else $error("Accepted word did not start a lookup.");

endmodule

>>> design/fdw_pres_map.sv
// Presence bitmap memory with its clearing sweep after reset.
module fdw_pres_map (
  input  logic              clk,
  input  logic              rst,
  input  fdw_pkg::pres_req_t req,
  output logic              rd_bit,
  output logic              clearing
);

  logic                     mem [fdw_pkg::ID_SPACE];
  logic [fdw_pkg::ID_W-1:0] sweep;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      sweep    <= '0;
    end else if (clearing) begin
      sweep <= sweep + 1'b1;
      if (sweep == fdw_pkg::ID_W'(fdw_pkg::ID_SPACE - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[sweep] <= 1'b0;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_bit;
    end
    if (req.rd_en) begin
      rd_bit <= mem[req.rd_addr];
    end
  end

endmodule

>>> design/fdw_ring.sv
// Identifier ring memory, addressed as offsets from the oldest entry.
module fdw_ring #(
  parameter int WINDOW_DEPTH = fdw_pkg::WINDOW_DEPTH_DEF,
  parameter int PTR_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
  parameter int CNT_W        = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic [PTR_W-1:0]         base,
  input  logic                     wr_en,
  input  logic [CNT_W-1:0]         wr_off,
  input  logic [fdw_pkg::ID_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [CNT_W-1:0]         rd_off,
  output logic [fdw_pkg::ID_W-1:0] rd_data
);

  localparam int SW = CNT_W + 1;

  logic [fdw_pkg::ID_W-1:0] mem [WINDOW_DEPTH];
  logic [SW-1:0]            wr_sum, rd_sum;
  logic [PTR_W-1:0]         wr_slot, rd_slot;

  always_comb begin
    wr_sum = SW'(base) + SW'(wr_off);
    rd_sum = SW'(base) + SW'(rd_off);
    if (wr_sum >= SW'(WINDOW_DEPTH)) begin
      wr_slot = PTR_W'(wr_sum - SW'(WINDOW_DEPTH));
    end else begin
      wr_slot = PTR_W'(wr_sum);
    end
    if (rd_sum >= SW'(WINDOW_DEPTH)) begin
      rd_slot = PTR_W'(rd_sum - SW'(WINDOW_DEPTH));
    end else begin
      rd_slot = PTR_W'(rd_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_slot];
    end
  end

endmodule
